@@ rtl/core/mppm_pkg.sv @@
// Package for the multi-pattern path matcher: item codes, cell control struct,
// marker word table and ASCII case folding. No dependencies.
`default_nettype none

package mppm_pkg;

  localparam int CHAR_W = 16;
  localparam int ACTION_W = 2;
  localparam int MARKER_CELLS = 25;

  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_PATH  = 2'd2;

  // "appdata", "profiles" and the decoy folder word, already folded
  localparam logic [CHAR_W-1:0] MARKER_CHAR [MARKER_CELLS] = '{
    16'h0061, 16'h0070, 16'h0070, 16'h0064, 16'h0061, 16'h0074, 16'h0061,
    16'h0070, 16'h0072, 16'h006f, 16'h0066, 16'h0069, 16'h006c, 16'h0065, 16'h0073,
    16'h0073, 16'h0068, 16'h0069, 16'h0065, 16'h006c, 16'h0064, 16'h0063, 16'h006f,
    16'h0072, 16'h0064
  };
  // first and final cell of each marker word
  localparam logic [MARKER_CELLS-1:0] MARKER_HEAD = 25'h0008081;
  localparam logic [MARKER_CELLS-1:0] MARKER_TAIL = 25'h1004040;

  typedef struct packed {
    logic clear;   // drop pattern table and its match state
    logic step;    // path character advances the cells
    logic flush;   // final path character, match state restarts afterwards
  } cell_ctrl_t;

  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] f;
    f = c;
    if (c >= 16'h0041 && c <= 16'h005a) begin
      f = c + 16'h0020;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/mppm_cell.sv @@
// One pattern character cell: stored character, end mark and partial-match bit.
// Depends on mppm_pkg.
`default_nettype none

module mppm_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  mppm_pkg::cell_ctrl_t        ctrl,
  input  logic                        wr_en,
  input  logic [mppm_pkg::CHAR_W-1:0] wr_char,
  input  logic                        wr_last,
  input  logic                        enable,
  input  logic                        prev,
  input  logic [mppm_pkg::CHAR_W-1:0] path_char,
  output logic                        partial,
  output logic                        hit_term
);
  import mppm_pkg::*;

  logic [CHAR_W-1:0] ch;
  logic              tail;
  logic              partial_next;

  assign partial_next = enable && prev && (ch == path_char);
  assign hit_term     = partial_next && tail;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ch <= wr_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      partial <= 1'b0;
      tail    <= 1'b0;
    end else begin
      if (wr_en) begin
        tail <= wr_last;
      end
      if (ctrl.step) begin
        partial <= ctrl.flush ? 1'b0 : partial_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mppm_row.sv @@
// One pattern slot: a chain of character cells plus active and hit flags.
// Depends on mppm_pkg and mppm_cell.
`default_nettype none

module mppm_row #(
  parameter int MAX_PATTERN_CHARS = 128,
  localparam int POS_W = $clog2(MAX_PATTERN_CHARS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mppm_pkg::cell_ctrl_t        ctrl,
  input  logic                        row_wr,
  input  logic                        commit,
  input  logic [POS_W-1:0]            wr_pos,
  input  logic [mppm_pkg::CHAR_W-1:0] wr_char,
  input  logic                        wr_last,
  input  logic [mppm_pkg::CHAR_W-1:0] path_char,
  output logic                        row_hit
);
  import mppm_pkg::*;

  logic                         active;
  logic                         hit;
  logic                         hit_next;
  logic [MAX_PATTERN_CHARS-1:0] partial;
  logic [MAX_PATTERN_CHARS-1:0] chain_in;
  logic [MAX_PATTERN_CHARS-1:0] terms;

  assign chain_in = {partial[MAX_PATTERN_CHARS-2:0], 1'b1};

  for (genvar k = 0; k < MAX_PATTERN_CHARS; k++) begin : g_cell
    mppm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .wr_en     (row_wr && (wr_pos == POS_W'(k))),
      .wr_char   (wr_char),
      .wr_last   (wr_last),
      .enable    (active),
      .prev      (chain_in[k]),
      .path_char (path_char),
      .partial   (partial[k]),
      .hit_term  (terms[k])
    );
  end

  assign hit_next = hit || (|terms);
  assign row_hit  = active && hit_next;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      active <= 1'b0;
      hit    <= 1'b0;
    end else begin
      if (commit) begin
        active <= 1'b1;
      end
      if (ctrl.step) begin
        hit <= ctrl.flush ? 1'b0 : hit_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mppm_marker.sv @@
// Fixed marker word cells: three words, each matched on its own against the path.
// Depends on mppm_pkg.
`default_nettype none

module mppm_marker (
  input  logic                        clk,
  input  logic                        rst,
  input  mppm_pkg::cell_ctrl_t        ctrl,
  input  logic [mppm_pkg::CHAR_W-1:0] path_char,
  output logic                        seen_next
);
  import mppm_pkg::*;

  logic [MARKER_CELLS-1:0] partial;
  logic [MARKER_CELLS-1:0] partial_next;
  logic [MARKER_CELLS-1:0] prev;
  logic                    seen;

  assign prev = {partial[MARKER_CELLS-2:0], 1'b1} | MARKER_HEAD;

  always_comb begin
    for (int i = 0; i < MARKER_CELLS; i++) begin
      partial_next[i] = prev[i] && (path_char == MARKER_CHAR[i]);
    end
  end

  assign seen_next = seen || (|(partial_next & MARKER_TAIL));

  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
      seen    <= 1'b0;
    end else if (ctrl.step) begin
      partial <= ctrl.flush ? '0 : partial_next;
      seen    <= ctrl.flush ? 1'b0 : seen_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/multi_pattern_path_matcher.sv @@
// Multi-pattern path matcher: pattern loader, rows of match cells, marker cells
// and a two-entry result queue. Depends on mppm_pkg, mppm_row, mppm_marker.
// Throughput: one item per cycle while the skid entry is empty; all cells
// advance on each path character. Each result is registered in the queue.
// Reset clears pattern table, match cells, marker state and the result queue;
// stored pattern characters are not reset.
`default_nettype none

module multi_pattern_path_matcher #(
  parameter int MAX_PATTERNS = 16,
  parameter int MAX_PATTERN_CHARS = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mppm_pkg::ACTION_W-1:0] action,
  input  logic [mppm_pkg::CHAR_W-1:0]   character,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          protected_res,
  output logic                          marker_found
);
  import mppm_pkg::*;

  localparam int TOT_W = $clog2(MAX_PATTERNS + 1);
  localparam int POS_W = $clog2(MAX_PATTERN_CHARS + 1);

  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] total_next;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             too_long;
  logic             too_long_next;

  logic              acc;
  logic              is_clear;
  logic              is_load;
  logic              is_path;
  logic              full;
  logic              room;
  logic              wr;
  logic              commit;
  logic              push;
  logic [CHAR_W-1:0] folded;
  cell_ctrl_t        ctrl;

  logic [MAX_PATTERNS-1:0] row_hits;
  logic                    seen_next;
  logic                    res_prot;

  logic skid_valid;
  logic skid_prot;
  logic skid_marker;
  logic pop;

  assign acc      = in_valid && in_ready;
  assign is_clear = acc && (action == ACT_CLEAR);
  assign is_load  = acc && (action == ACT_LOAD);
  assign is_path  = acc && (action == ACT_PATH);
  assign folded   = fold_char(character);

  assign full   = (total == TOT_W'(MAX_PATTERNS));
  assign room   = !too_long && (pos != POS_W'(MAX_PATTERN_CHARS));
  assign wr     = is_load && !full && room;
  assign commit = wr && last;

  assign ctrl.clear = is_clear;
  assign ctrl.step  = is_path;
  assign ctrl.flush = is_path && last;

  always_comb begin
    total_next    = total;
    pos_next      = pos;
    too_long_next = too_long;
    if (is_clear) begin
      total_next    = '0;
      pos_next      = '0;
      too_long_next = 1'b0;
    end else if (is_load) begin
      if (!full && !room) begin
        too_long_next = 1'b1;
      end
      if (wr) begin
        pos_next = pos + POS_W'(1);
      end
      if (commit) begin
        total_next = total + TOT_W'(1);
      end
      if (last) begin
        pos_next      = '0;
        too_long_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= '0;
      pos      <= '0;
      too_long <= 1'b0;
    end else begin
      total    <= total_next;
      pos      <= pos_next;
      too_long <= too_long_next;
    end
  end

  for (genvar p = 0; p < MAX_PATTERNS; p++) begin : g_row
    mppm_row #(
      .MAX_PATTERN_CHARS (MAX_PATTERN_CHARS)
    ) u_row (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .row_wr    (wr && (total == TOT_W'(p))),
      .commit    (commit && (total == TOT_W'(p))),
      .wr_pos    (pos),
      .wr_char   (folded),
      .wr_last   (last),
      .path_char (folded),
      .row_hit   (row_hits[p])
    );
  end

  mppm_marker u_marker (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .path_char (folded),
    .seen_next (seen_next)
  );

  assign res_prot = seen_next && (|row_hits);

  // result queue: output register with a skid entry behind it
  assign push     = ctrl.flush;
  assign pop      = out_valid && out_ready;
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
        end
      end else if (!out_valid) begin
        out_valid <= push;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((pop && skid_valid)) begin
      protected_res <= skid_prot;
      marker_found  <= skid_marker;
    end else if (push && (pop || !out_valid)) begin
      protected_res <= res_prot;
      marker_found  <= seen_next;
    end
    if (push && out_valid && !pop) begin
      skid_prot   <= res_prot;
      skid_marker <= seen_next;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without output entry");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= TOT_W'(MAX_PATTERNS))
    else $error("pattern count beyond table size");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (action == ACT_PATH) && last) |=> out_valid)
    else $error("final path item gave no result");

  a_prot_needs_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!protected_res || marker_found))
    else $error("protected result without marker");

  a_clear_resets_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (action == ACT_CLEAR)) |=> (total == '0 && pos == '0))
    else $error("clear left load state behind");

endmodule

`default_nettype wire
